>>> rtl/core/qsf_pkg.sv
// Shared types and constants of the QUBO single-flip Trotter step core.
// No dependencies; compiled first.
`default_nettype none

package qsf_pkg;

  // Default array sizes
  localparam int NUM_BITS_DEF   = 64;
  localparam int NUM_LAYERS_DEF = 4;

  // Configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 47;

  localparam logic [CFG_INDEX_W-1:0] REG_ENERGY_WEIGHT    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TROTTER_COUPLING = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DELTA_CLAMP      = 2'd2;

  localparam logic [31:0] ENERGY_WEIGHT_RST    = 32'd65536;
  localparam logic [31:0] TROTTER_COUPLING_RST = 32'd0;
  localparam logic [46:0] DELTA_CLAMP_RST      = 47'd65536000000;

  // Request codes
  localparam logic [1:0] REQ_LOAD_ENTRY = 2'd0;
  localparam logic [1:0] REQ_LOAD_SPIN  = 2'd1;
  localparam logic [1:0] REQ_FLIP       = 2'd2;

  // Input item
  typedef struct packed {
    logic [1:0]         req_type;
    logic [1:0]         layer_index;
    logic [5:0]         row_index;
    logic [5:0]         col_index;
    logic signed [31:0] entry_value;
    logic signed [47:0] accept_threshold;
  } item_t;

  // Result item
  typedef struct packed {
    logic               accepted;
    logic signed [47:0] delta_energy;
    logic               spin_now;
  } result_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_LOAD,
    ST_SPIN_RD,
    ST_SUM,
    ST_MUL,
    ST_ACC,
    ST_TERM,
    ST_CLAMP,
    ST_DECIDE,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

>>> rtl/core/qsf_stream_if.sv
// Valid/ready stream channel carrying one payload item per handshake.
// Payload type is a parameter; no other dependencies.
`default_nettype none

interface qsf_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

>>> rtl/core/qsf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No package dependency.
`default_nettype none

module qsf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire                       clk,
  input  wire                       we,
  input  wire [$clog2(DEPTH)-1:0]   waddr,
  input  wire [WIDTH-1:0]           wdata,
  input  wire [$clog2(DEPTH)-1:0]   raddr,
  output logic [WIDTH-1:0]          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/core/qubo_single_flip_trotter_step_core.sv
// Top level of the QUBO single-flip Trotter step core.
// Depends on qsf_pkg, qsf_stream_if and qsf_ram.
`default_nettype none

// Holds a NUM_BITS x NUM_BITS coupling matrix and NUM_LAYERS x NUM_BITS spins,
// both in RAM and undefined until loaded. Every item returns one result item.
// Load items and the unused request code pass through the load state. Any item
// first wraps its out-of-range indexes by repeated subtraction; indexes wrap in
// parallel, none at the default sizes. A flip trial forms a row sum and
// multiplies it by the energy weight in ND digits, where
// ND = ceil((32+log2 NUM_BITS)/16): the row sum reads one coupling entry and
// one spin per cycle through the single read port of each RAM, and the
// weight product runs through one 16x32 multiplier, one 16-bit digit at a
// time, a multiply step and then an accumulate step per digit.
// The input is ready only while the sequencer is idle; a finished result
// waits in the output register, so the next item is taken while it is held.
module qubo_single_flip_trotter_step_core #(
  parameter int NUM_BITS   = qsf_pkg::NUM_BITS_DEF,
  parameter int NUM_LAYERS = qsf_pkg::NUM_LAYERS_DEF
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             cfg_we,
  input  wire [qsf_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire [qsf_pkg::CFG_DATA_W-1:0]   cfg_data,
  qsf_stream_if.sink                      req,
  qsf_stream_if.source                    rsp
);

  import qsf_pkg::*;

  localparam int BW  = $clog2(NUM_BITS);
  localparam int LW  = $clog2(NUM_LAYERS);
  localparam int RRW = (BW > 6) ? BW : 6;
  localparam int LRW = (LW > 2) ? LW : 2;
  localparam int CDEPTH = NUM_BITS << BW;
  localparam int SDEPTH = NUM_LAYERS << BW;
  localparam int SW  = 32 + BW;          // row sum width
  localparam int ND  = (SW + 15) / 16;   // multiplier digits
  localparam int UW  = ND * 16;
  localparam int AW  = UW + 32;          // product accumulator
  localparam int PW  = AW - 16;          // product after dropping 16 fraction bits
  localparam int DEW = PW + 2;           // energy change before the clamp
  localparam int JW  = $clog2(NUM_BITS + 1);
  localparam int DW  = $clog2(ND);

  localparam logic [31:0]    NB_U     = 32'(NUM_BITS);
  localparam logic [31:0]    NL_U     = 32'(NUM_LAYERS);
  localparam logic [RRW-1:0] NB_R     = RRW'(NUM_BITS);
  localparam logic [LRW-1:0] NL_R     = LRW'(NUM_LAYERS);
  localparam logic [LW-1:0]  LAY_LAST = LW'(NUM_LAYERS - 1);
  localparam logic [JW-1:0]  J_END    = JW'(NUM_BITS);
  localparam logic [DW-1:0]  DIG_LAST = DW'(ND - 1);

  // Configuration registers
  logic [31:0] energy_weight;
  logic [31:0] trotter_coupling;
  logic [46:0] delta_clamp;

  // Sequencer and item registers
  state_t         state, state_next;
  item_t          item;
  logic [RRW-1:0] row_q;
  logic [RRW-1:0] col_q;
  logic [LRW-1:0] layer_q;
  logic [1:0]     phase;

  // Flip datapath registers
  logic                  old_spin;
  logic                  nbr_next;
  logic                  nbr_prev;
  logic [JW-1:0]         j;
  logic [BW-1:0]         j_last;
  logic                  pend;
  logic signed [SW-1:0]  sum;
  logic                  sum_neg;
  logic [31:0]           wm;
  logic [UW-1:0]         um_sh;
  logic [47:0]           prod;
  logic [AW-1:0]         mac;
  logic [DW-1:0]         dig;
  logic signed [DEW-1:0] de;
  logic signed [47:0]    de_c;
  result_t               res;

  // Output register
  logic    out_valid;
  result_t out_data;

  // Combinational helpers
  logic                  row_ge, col_ge, lay_ge, need_wrap;
  logic [BW-1:0]         bit_idx, col_idx, s_rd_bit;
  logic [LW-1:0]         lay, lay_next, lay_prev, s_rd_lay;
  logic                  new_spin, spin_term, j_lt, sum_done, out_free;
  logic [SW-1:0]         sum_abs;
  logic [31:0]           ew_abs;
  logic                  prod_neg, t2_zero, t2_neg;
  logic [PW-1:0]         p_mag;
  logic signed [PW:0]    t1;
  logic signed [33:0]    c2, t2;
  logic signed [DEW-1:0] clamp_s, clamp_n;
  logic                  flip_ok;

  // RAM ports
  logic          c_we, s_we, s_wdata, s_rdata;
  logic [31:0]   c_rdata;

  // Index wrapping and addressing
  assign row_ge    = 32'(row_q) >= NB_U;
  assign col_ge    = 32'(col_q) >= NB_U;
  assign lay_ge    = 32'(layer_q) >= NL_U;
  assign need_wrap = row_ge | col_ge | lay_ge;
  assign bit_idx   = row_q[BW-1:0];
  assign col_idx   = col_q[BW-1:0];
  assign lay       = layer_q[LW-1:0];
  assign lay_next  = (lay == LAY_LAST) ? '0 : lay + LW'(1);
  assign lay_prev  = (lay == '0) ? LAY_LAST : lay - LW'(1);

  // Spin RAM read address: own bit, neighbor layers, then the row sweep
  always_comb begin
    s_rd_lay = lay;
    s_rd_bit = bit_idx;
    if (state == ST_SPIN_RD && phase == 2'd1) begin
      s_rd_lay = lay_next;
    end else if (state == ST_SPIN_RD && phase == 2'd2) begin
      s_rd_lay = lay_prev;
    end else if (state == ST_SUM) begin
      s_rd_bit = j[BW-1:0];
    end
  end

  // Row sum control; the flipped bit counts with its tentative value
  assign new_spin  = ~old_spin;
  assign spin_term = (j_last == bit_idx) ? new_spin : s_rdata;
  assign j_lt      = j < J_END;
  assign sum_done  = !j_lt && !pend;
  assign sum_abs   = sum[SW-1] ? SW'(-sum) : SW'(sum);
  assign ew_abs    = energy_weight[31] ? (32'd0 - energy_weight) : energy_weight;

  // Energy terms
  assign prod_neg = sum_neg ^ energy_weight[31] ^ ~new_spin;
  assign p_mag    = mac[AW-1:16];
  assign t1       = prod_neg ? -signed'({1'b0, p_mag}) : signed'({1'b0, p_mag});
  assign c2       = signed'({{2{trotter_coupling[31]}}, trotter_coupling}) <<< 1;
  assign t2_zero  = nbr_next ^ nbr_prev;
  assign t2_neg   = ~new_spin ^ ~nbr_next;
  assign t2       = t2_zero ? '0 : (t2_neg ? -c2 : c2);
  assign clamp_s  = signed'(DEW'(delta_clamp));
  assign clamp_n  = -clamp_s;
  assign flip_ok  = de_c < item.accept_threshold;

  assign out_free = !out_valid || rsp.ready;

  // RAM write controls
  assign c_we    = (state == ST_LOAD) && (item.req_type == REQ_LOAD_ENTRY);
  assign s_we    = ((state == ST_LOAD) && (item.req_type == REQ_LOAD_SPIN)) ||
                   ((state == ST_DECIDE) && flip_ok);
  assign s_wdata = (state == ST_LOAD) ? item.entry_value[0] : new_spin;

  qsf_ram #(
    .WIDTH (32),
    .DEPTH (CDEPTH)
  ) u_coupling_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr ({bit_idx, col_idx}),
    .wdata (item.entry_value),
    .raddr ({bit_idx, j[BW-1:0]}),
    .rdata (c_rdata)
  );

  qsf_ram #(
    .WIDTH (1),
    .DEPTH (SDEPTH)
  ) u_spin_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr ({lay, bit_idx}),
    .wdata (s_wdata),
    .raddr ({s_rd_lay, s_rd_bit}),
    .rdata (s_rdata)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      energy_weight    <= ENERGY_WEIGHT_RST;
      trotter_coupling <= TROTTER_COUPLING_RST;
      delta_clamp      <= DELTA_CLAMP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ENERGY_WEIGHT:    energy_weight    <= cfg_data[31:0];
        REG_TROTTER_COUPLING: trotter_coupling <= cfg_data[31:0];
        REG_DELTA_CLAMP:      delta_clamp      <= cfg_data;
        default: ;
      endcase
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req.valid) state_next = ST_REDUCE;
      end
      ST_REDUCE: begin
        if (!need_wrap) begin
          state_next = (item.req_type == REQ_FLIP) ? ST_SPIN_RD : ST_LOAD;
        end
      end
      ST_LOAD:    state_next = ST_DONE;
      ST_SPIN_RD: begin
        if (phase == 2'd3) state_next = ST_SUM;
      end
      ST_SUM: begin
        if (sum_done) state_next = ST_MUL;
      end
      ST_MUL:     state_next = ST_ACC;
      ST_ACC:     state_next = (dig == DIG_LAST) ? ST_TERM : ST_MUL;
      ST_TERM:    state_next = ST_CLAMP;
      ST_CLAMP:   state_next = ST_DECIDE;
      ST_DECIDE:  state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default:    state_next = ST_IDLE;
    endcase
  end

  assign req.ready = (state == ST_IDLE);

  // Datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (req.valid) begin
          item    <= req.data;
          row_q   <= RRW'(req.data.row_index);
          col_q   <= RRW'(req.data.col_index);
          layer_q <= LRW'(req.data.layer_index);
        end
      end
      ST_REDUCE: begin
        // wrap out-of-range indexes, one subtract per cycle
        if (row_ge) row_q <= row_q - NB_R;
        if (col_ge) col_q <= col_q - NB_R;
        if (lay_ge) layer_q <= layer_q - NL_R;
        phase <= 2'd0;
      end
      ST_LOAD: begin
        res.accepted     <= 1'b0;
        res.delta_energy <= '0;
        res.spin_now     <= (item.req_type == REQ_LOAD_SPIN) ? item.entry_value[0] : 1'b0;
      end
      ST_SPIN_RD: begin
        // read data is registered and arrives in the cycle after its address
        phase <= phase + 2'd1;
        if (phase == 2'd1) old_spin <= s_rdata;
        if (phase == 2'd2) nbr_next <= s_rdata;
        if (phase == 2'd3) begin
          nbr_prev <= s_rdata;
          j        <= '0;
          pend     <= 1'b0;
          sum      <= '0;
        end
      end
      ST_SUM: begin
        if (pend && spin_term) begin
          sum <= sum + signed'({{BW{c_rdata[31]}}, c_rdata});
        end
        if (j_lt) begin
          j      <= j + JW'(1);
          j_last <= j[BW-1:0];
          pend   <= 1'b1;
        end else begin
          pend <= 1'b0;
        end
        if (sum_done) begin
          um_sh   <= UW'(sum_abs);
          sum_neg <= sum[SW-1];
          wm      <= ew_abs;
          mac     <= '0;
          dig     <= '0;
        end
      end
      ST_MUL: begin
        // shared 16x32 multiplier, most significant digit first
        prod <= 48'(um_sh[UW-1 -: 16]) * 48'(wm);
      end
      ST_ACC: begin
        mac   <= {mac[AW-17:0], 16'd0} + AW'(prod);
        um_sh <= {um_sh[UW-17:0], 16'd0};
        dig   <= dig + DW'(1);
      end
      ST_TERM: begin
        de <= DEW'(t1) + DEW'(t2);
      end
      ST_CLAMP: begin
        if (de > clamp_s) begin
          de_c <= clamp_s[47:0];
        end else if (de < clamp_n) begin
          de_c <= clamp_n[47:0];
        end else begin
          de_c <= de[47:0];
        end
      end
      ST_DECIDE: begin
        res.accepted     <= flip_ok;
        res.delta_energy <= de_c;
        res.spin_now     <= flip_ok ? new_spin : old_spin;
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      out_data <= res;
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

endmodule

`default_nettype wire

>>> rtl/core/qsf_checker.sv
// Port-level checker for the QUBO single-flip Trotter step core, plus its bind.
// Depends on qsf_pkg and the top level.
`default_nettype none

module qsf_checker (
  input wire                   clk,
  input wire                   rst,
  input wire                   req_valid,
  input wire                   req_ready,
  input wire                   rsp_valid,
  input wire                   rsp_ready,
  input wire qsf_pkg::result_t rsp_data
);

  import qsf_pkg::*;

  logic       req_fire, rsp_fire;
  logic [1:0] pend;

  assign req_fire = req_valid && req_ready;
  assign rsp_fire = rsp_valid && rsp_ready;

  // Items taken whose result has not been delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 2'd0;
    end else if (req_fire && !rsp_fire) begin
      pend <= pend + 2'd1;
    end else if (rsp_fire && !req_fire) begin
      pend <= pend - 2'd1;
    end
  end

  // A stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("result changed or dropped while stalled");

  // No result without an outstanding item
  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> pend != 2'd0)
    else $error("result shown with no item outstanding");

  // At most one item in work and one result waiting
  a_depth: assert property (@(posedge clk) disable iff (rst)
    pend != 2'd3)
    else $error("more than two items outstanding");

  // Taking an item drops input ready
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_fire |=> !req_ready)
    else $error("input ready right after an item was taken");

endmodule

bind qubo_single_flip_trotter_step_core qsf_checker u_qsf_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_data  (rsp.data)
);

`default_nettype wire
